// ===== rtl/core/dvrt_pkg.sv =====
// Shared types and constants for the distance-vector route table.
// No dependencies; imported by every module of the block but dvrt_ram.
package dvrt_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);

   localparam logic [15:0] COST_MAX = 16'hFFFF;

   // input item kinds
   localparam logic [1:0] ACT_ADVERT = 2'd0;
   localparam logic [1:0] ACT_LINK   = 2'd1;
   localparam logic [1:0] ACT_DUMP   = 2'd2;

   // result status codes
   localparam logic [2:0] RS_OK      = 3'd0;
   localparam logic [2:0] RS_UNKNOWN = 3'd1;
   localparam logic [2:0] RS_FULL    = 3'd2;
   localparam logic [2:0] RS_OWN     = 3'd3;
   localparam logic [2:0] RS_EMPTY   = 3'd4;

   typedef struct packed {
      logic [15:0] cost;
      logic [7:0]  gateway;
      logic [7:0]  destination;
   } dvrt_entry_type;

   localparam int ENTRY_W = $bits(dvrt_entry_type);

   // controller -> datapath
   typedef struct packed {
      logic load_item;
      logic scan_run;
      logic calc;
      logic commit;
      logic dump_emit;
   } dvrt_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic [1:0] req_action;
      logic       scan_done;
      logic       out_free;
      logic       dump_done;
   } dvrt_stat_type;

endpackage

// ===== rtl/core/dvrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dvrt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dvrt_ctrl.sv =====
// Sequencing state machine for the route table: scan, update, dump.
// Depends on dvrt_pkg.
module dvrt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  dvrt_pkg::dvrt_stat_type stat,
   output dvrt_pkg::dvrt_cmd_type  cmd
);
   import dvrt_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_SCAN     = 6'b000010,
      S_CALC     = 6'b000100,
      S_COMMIT   = 6'b001000,
      S_DUMP_RD  = 6'b010000,
      S_DUMP_OUT = 6'b100000
   } dvrt_state_type;

   dvrt_state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load_item = 1'b1;
               unique case (stat.req_action)
                  ACT_ADVERT, ACT_LINK: state_in = S_SCAN;
                  ACT_DUMP:             state_in = S_DUMP_RD;
                  default:              state_in = S_IDLE;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            cmd.calc = 1'b1;
            state_in = S_COMMIT;
         end
         S_COMMIT: begin
            if (stat.out_free) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DUMP_RD: begin
            state_in = S_DUMP_OUT;
         end
         S_DUMP_OUT: begin
            if (stat.out_free) begin
               cmd.dump_emit = 1'b1;
               state_in      = stat.dump_done ? S_IDLE : S_DUMP_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/dvrt_dp.sv =====
// Datapath: table memory, item registers, scan compare, update and result register.
// Depends on dvrt_pkg and dvrt_ram.
module dvrt_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  dvrt_pkg::dvrt_cmd_type  cmd,
   output dvrt_pkg::dvrt_stat_type stat,
   input  logic [31:0]            req_tdata,
   input  logic [1:0]             req_tuser,
   input  logic                   csr_we,
   input  logic [7:0]             csr_wdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [31:0]            rsp_tdata,
   output logic                   rsp_tlast,
   output logic [2:0]             rsp_tuser
);
   import dvrt_pkg::*;

   // control registers
   logic [7:0]         own_ff, own_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] idx_ff, idx_in;
   logic               pend_ff, pend_in;
   logic               key_found_ff, key_found_in;
   logic               link_found_ff, link_found_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [1:0]         act_ff, act_in;
   logic [7:0]         nb_ff, nb_in;
   logic [7:0]         key_ff, key_in;
   logic [15:0]        cost_ff, cost_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [IDX_W-1:0]   key_idx_ff, key_idx_in;
   logic [7:0]         key_hop_ff, key_hop_in;
   logic [15:0]        key_cost_ff, key_cost_in;
   logic [15:0]        link_cost_ff, link_cost_in;
   logic [15:0]        newcost_ff, newcost_in;
   dvrt_entry_type     rsp_entry_ff, rsp_entry_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [2:0]         rsp_status_ff, rsp_status_in;

   logic [ENTRY_W-1:0] rd_data;
   dvrt_entry_type     rd_entry;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr;
   dvrt_entry_type     wr_entry;

   logic [COUNT_W-1:0] idx_inc;
   logic [16:0]        sum;
   logic               is_link;
   logic               upd;
   logic               table_full;
   logic               out_free;
   dvrt_entry_type     new_entry;
   dvrt_entry_type     err_entry;

   dvrt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_entry   = rd_data;
   assign idx_inc    = idx_ff + COUNT_W'(1);
   assign sum        = {1'b0, cost_ff} + {1'b0, link_cost_ff};
   assign is_link    = (act_ff == ACT_LINK);
   assign table_full = (count_ff == COUNT_W'(TABLE_DEPTH));
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign upd        = (key_hop_ff == nb_ff) ||
                       (is_link ? (newcost_ff <= key_cost_ff) : (newcost_ff < key_cost_ff));
   assign new_entry  = '{cost: newcost_ff, gateway: nb_ff, destination: key_ff};
   assign err_entry  = '{cost: 16'd0, gateway: 8'd0, destination: key_ff};

   assign stat.req_action = req_tuser;
   assign stat.scan_done  = (idx_ff == count_ff) && !pend_ff;
   assign stat.out_free   = out_free;
   assign stat.dump_done  = (count_ff == '0) || (idx_inc == count_ff);

   always_comb begin
      own_in        = csr_we ? csr_wdata : own_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      pend_in       = pend_ff;
      key_found_in  = key_found_ff;
      link_found_in = link_found_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      act_in        = act_ff;
      nb_in         = nb_ff;
      key_in        = key_ff;
      cost_in       = cost_ff;
      pend_idx_in   = pend_idx_ff;
      key_idx_in    = key_idx_ff;
      key_hop_in    = key_hop_ff;
      key_cost_in   = key_cost_ff;
      link_cost_in  = link_cost_ff;
      newcost_in    = newcost_ff;
      rsp_entry_in  = rsp_entry_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_status_in = rsp_status_ff;
      wr_en         = 1'b0;
      wr_addr       = key_idx_ff;
      wr_entry      = new_entry;

      if (cmd.load_item) begin
         act_in        = req_tuser;
         nb_in         = req_tdata[7:0];
         key_in        = (req_tuser == ACT_LINK) ? req_tdata[7:0] : req_tdata[15:8];
         cost_in       = req_tdata[31:16];
         idx_in        = '0;
         pend_in       = 1'b0;
         key_found_in  = 1'b0;
         link_found_in = 1'b0;
      end

      // pipelined scan: issue one address, compare the previous one
      if (cmd.scan_run) begin
         if (idx_ff < count_ff) begin
            idx_in      = idx_inc;
            pend_in     = 1'b1;
            pend_idx_in = idx_ff[IDX_W-1:0];
         end else begin
            pend_in = 1'b0;
         end
         if (pend_ff) begin
            if (!key_found_ff && rd_entry.destination == key_ff) begin
               key_found_in = 1'b1;
               key_idx_in   = pend_idx_ff;
               key_hop_in   = rd_entry.gateway;
               key_cost_in  = rd_entry.cost;
            end
            if (!link_found_ff && rd_entry.destination == nb_ff) begin
               link_found_in = 1'b1;
               link_cost_in  = rd_entry.cost;
            end
         end
      end

      if (cmd.calc) begin
         if (is_link) begin
            newcost_in = cost_ff;
         end else begin
            newcost_in = sum[16] ? COST_MAX : sum[15:0];
         end
      end

      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         priority if (!is_link && !link_found_ff) begin
            rsp_status_in = RS_UNKNOWN;
            rsp_entry_in  = err_entry;
         end else if (!is_link && key_ff == own_ff) begin
            rsp_status_in = RS_OWN;
            rsp_entry_in  = err_entry;
         end else if (key_found_ff) begin
            rsp_status_in = RS_OK;
            wr_en         = upd;
            wr_addr       = key_idx_ff;
            rsp_entry_in  = upd ? new_entry
                                : '{cost: key_cost_ff, gateway: key_hop_ff,
                                    destination: key_ff};
         end else if (table_full) begin
            rsp_status_in = RS_FULL;
            rsp_entry_in  = err_entry;
         end else begin
            rsp_status_in = RS_OK;
            wr_en         = 1'b1;
            wr_addr       = count_ff[IDX_W-1:0];
            count_in      = count_ff + COUNT_W'(1);
            rsp_entry_in  = new_entry;
         end
      end

      // poison reverse on routes learned from the dump receiver
      if (cmd.dump_emit) begin
         rsp_valid_in = 1'b1;
         if (count_ff == '0) begin
            rsp_status_in = RS_EMPTY;
            rsp_last_in   = 1'b1;
            rsp_entry_in  = '0;
         end else begin
            rsp_status_in = RS_OK;
            rsp_last_in   = (idx_inc == count_ff);
            rsp_entry_in  = rd_entry;
            if (rd_entry.gateway == nb_ff) begin
               rsp_entry_in.cost = COST_MAX;
            end
            idx_in = idx_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff        <= '0;
         count_ff      <= '0;
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         key_found_ff  <= 1'b0;
         link_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         own_ff        <= own_in;
         count_ff      <= count_in;
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         key_found_ff  <= key_found_in;
         link_found_ff <= link_found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      nb_ff         <= nb_in;
      key_ff        <= key_in;
      cost_ff       <= cost_in;
      pend_idx_ff   <= pend_idx_in;
      key_idx_ff    <= key_idx_in;
      key_hop_ff    <= key_hop_in;
      key_cost_ff   <= key_cost_in;
      link_cost_ff  <= link_cost_in;
      newcost_ff    <= newcost_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_entry_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

// ===== rtl/core/distance_vector_route_table.sv =====
// Top level of the distance-vector route table with poison reverse.
// Depends on dvrt_pkg, dvrt_ctrl, dvrt_dp (which holds the dvrt_ram table).
//
// Usage:
//  - req_* carries one item: a link cost update, a neighbor advert entry or
//    a dump request (kind in req_tuser). Accepted when req_tvalid & req_tready.
//  - rsp_* returns results: one per update or advert; one per table entry
//    for a dump (RS_EMPTY if none, rsp_tlast on the last), status in rsp_tuser.
//  - csr_we/csr_wdata write own_node_id; write only while the block is idle.
// Operation:
//  - update/advert: the table is searched one entry per cycle through the
//    single read port of the RAM.
//  - dump: per entry an address step then a result step, one RAM read each.
//  - action 3 is dropped with no result.
// The result sits in an output register, so the next item is taken while a
// result waits; a stalled rsp_tready holds the result and, once the next
// item needs the output register, holds that item's sequencer too.
// Reset (synchronous, active high) empties the table (count back to zero),
// clears own_node_id and drops any pending result. No clearing pass is
// needed; entries beyond the count are never read.
module distance_vector_route_table (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: neighbor_id[7:0], destination_id[15:8], cost_in[31:16]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,
   // req_tuser: action[1:0]
   input  logic [1:0]  req_tuser,
   // rsp_tdata: route_destination[7:0], route next hop[15:8], route_cost[31:16]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic        rsp_tlast,
   // rsp_tuser: status[2:0]
   output logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import dvrt_pkg::*;

   dvrt_cmd_type  cmd;
   dvrt_stat_type stat;

   // sequencer: decides scan / calc / commit / dump steps
   dvrt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // table, search compare, saturating sum, result register
   dvrt_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== rtl/core/dvrt_checker.sv =====
// Port-level checks for the route table, bound to the top level.
// Depends on dvrt_pkg and distance_vector_route_table.
module dvrt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [2:0]  rsp_tuser
);
   import dvrt_pkg::*;

   // a result held by the receiver does not change
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // reset drops any pending result
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // only dump items give more than one result, and those are all ok
   a_mid_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tuser == RS_OK)
      else $error("non-final result with error status");

   // error and empty results are single and carry no route
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != RS_OK |-> rsp_tlast && rsp_tdata[31:8] == '0)
      else $error("error result with route fields or not final");

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (.*);

// ===== tb/distance_vector_route_table_checker.sv =====
// Checker for the distance-vector route table: watches the item and result
// channels and the own-id write port, predicts every route report and compares.
// Depends on dvrt_pkg.
`timescale 1ns / 100ps

module distance_vector_route_table_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic [2:0]  rsp_tuser,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata,
   output int          mismatch_count,
   output int          pending_results
);
   import dvrt_pkg::*;

   typedef struct packed {
      logic [7:0]  destination;
      logic [7:0]  gateway;
      logic [15:0] cost;
      logic        last_flag;
      logic [2:0]  status;
   } route_report_type;

   // shadow copy of the route table
   logic [7:0]  route_dest [TABLE_DEPTH];
   logic [7:0]  route_hop  [TABLE_DEPTH];
   logic [15:0] route_cost [TABLE_DEPTH];
   int          route_count;
   logic [7:0]  own_id;

   route_report_type route_reports_due[$];

   function automatic int find_route(input logic [7:0] dest);
      for (int i = 0; i < route_count; i++) begin
         if (route_dest[i] == dest) return i;
      end
      return -1;
   endfunction

   task automatic queue_report(input logic [7:0] dest, input logic [7:0] hop,
                               input logic [15:0] cost, input logic last_flag,
                               input logic [2:0] status);
      route_reports_due.push_back('{dest, hop, cost, last_flag, status});
   endtask

   task automatic append_route(input logic [7:0] dest, input logic [7:0] hop,
                               input logic [15:0] cost, output int idx);
      if (route_count >= TABLE_DEPTH) begin
         idx = -1;
      end else begin
         idx = route_count;
         route_dest[idx] = dest;
         route_hop[idx]  = hop;
         route_cost[idx] = cost;
         route_count++;
      end
   endtask

   task automatic update_routes(input logic [1:0] action, input logic [7:0] nb,
                                input logic [7:0] dest, input logic [15:0] cost);
      int          idx;
      int          link;
      logic [16:0] sum;
      logic [15:0] path_cost;
      logic [15:0] shown_cost;
      case (action)
         ACT_LINK: begin
            idx = find_route(nb);
            if (idx < 0) begin
               append_route(nb, nb, cost, idx);
            end else if (cost <= route_cost[idx] || route_hop[idx] == nb) begin
               route_cost[idx] = cost;
               route_hop[idx]  = nb;
            end
            if (idx < 0) queue_report(nb, 8'd0, 16'd0, 1'b1, RS_FULL);
            else queue_report(route_dest[idx], route_hop[idx], route_cost[idx],
                              1'b1, RS_OK);
         end
         ACT_ADVERT: begin
            link = find_route(nb);
            if (link < 0) begin
               queue_report(dest, 8'd0, 16'd0, 1'b1, RS_UNKNOWN);
            end else if (dest == own_id) begin
               queue_report(dest, 8'd0, 16'd0, 1'b1, RS_OWN);
            end else begin
               sum       = {1'b0, cost} + {1'b0, route_cost[link]};
               path_cost = sum[16] ? COST_MAX : sum[15:0];
               idx       = find_route(dest);
               if (idx < 0) begin
                  append_route(dest, nb, path_cost, idx);
               end else if (route_hop[idx] == nb) begin
                  route_cost[idx] = path_cost;
               end else if (route_cost[idx] > path_cost) begin
                  route_cost[idx] = path_cost;
                  route_hop[idx]  = nb;
               end
               if (idx < 0) queue_report(dest, 8'd0, 16'd0, 1'b1, RS_FULL);
               else queue_report(route_dest[idx], route_hop[idx], route_cost[idx],
                                 1'b1, RS_OK);
            end
         end
         ACT_DUMP: begin
            if (route_count == 0) begin
               queue_report(8'd0, 8'd0, 16'd0, 1'b1, RS_EMPTY);
            end else begin
               for (int i = 0; i < route_count; i++) begin
                  // poison reverse toward the receiving neighbor
                  shown_cost = (route_hop[i] == nb) ? COST_MAX : route_cost[i];
                  queue_report(route_dest[i], route_hop[i], shown_cost,
                               i == route_count - 1, RS_OK);
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic log_failure(input string why, input route_report_type want);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t %s: want dest %h hop %h cost %h last %b status %0d,",
                   " got dest %h hop %h cost %h last %b status %0d"},
                  $time, why, want.destination, want.gateway, want.cost,
                  want.last_flag, want.status, rsp_tdata[7:0], rsp_tdata[15:8],
                  rsp_tdata[31:16], rsp_tlast, rsp_tuser);
   endtask

   always @(posedge clock) begin : watch
      route_report_type want;
      if (reset) begin
         route_count = 0;
         own_id      = 8'd0;
         route_reports_due.delete();
      end else begin
         if (csr_we) own_id = csr_wdata;
         if (req_tvalid && req_tready)
            update_routes(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[31:16]);
         if (rsp_tvalid && rsp_tready) begin
            if (route_reports_due.size() == 0) begin
               log_failure("result with nothing due", '0);
            end else begin
               want = route_reports_due.pop_front();
               if (rsp_tdata[7:0] !== want.destination ||
                   rsp_tdata[15:8] !== want.gateway ||
                   rsp_tdata[31:16] !== want.cost || rsp_tlast !== want.last_flag ||
                   rsp_tuser !== want.status)
                  log_failure("route report mismatch", want);
            end
         end
      end
      pending_results = route_reports_due.size();
   end

endmodule

// ===== tb/distance_vector_route_table_tb.sv =====
// Testbench top for the distance-vector route table: drives items, own-id
// writes and result back-pressure, and gives the verdict.
// Depends on dvrt_pkg, distance_vector_route_table and its checker module.
`timescale 1ns / 100ps

module distance_vector_route_table_tb;
   import dvrt_pkg::*;

   // action code 3 is not used by the block: dropped with no result
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Longest correct stretch without any handshake: the receiver hold-off
   // (HOLD_CYCLES), plus a sender gap, a search and the settle pad
   // (SETTLE_CYCLES). The limit takes that several times over.
   localparam int HOLD_CYCLES   = 400;
   localparam int SETTLE_CYCLES = 100;
   localparam int IDLE_LIMIT    = 4000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // neighbor_id[7:0], destination_id[15:8], cost_in[31:16]
   logic [1:0]  req_tuser  = '0;   // action[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // rsp_tdata: route_destination[7:0], route next hop[15:8], route_cost[31:16]
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic [2:0]  rsp_tuser;         // status[2:0]
   logic        csr_we     = 1'b0;
   logic [7:0]  csr_wdata  = '0;

   int mismatch_count;
   int pending_results;

   // sender burst control
   int burst_left = 0;
   bit gaps_on    = 1'b1;
   // set by the stimulus to ask for one long receiver hold-off; cleared when done
   bit hold_go    = 1'b0;

   distance_vector_route_table dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   distance_vector_route_table_checker route_watch (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tlast       (rsp_tlast),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one item and hold it until taken. Between bursts valid drops for
   // a random gap; a zero gap or a long burst keeps the input busy.
   task automatic offer_item(input logic [1:0] act, input logic [7:0] nb,
                             input logic [7:0] dest, input logic [15:0] cost);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {cost, dest, nb};
      do @(posedge clock); while (!req_tready);
      if (burst_left > 0) begin
         burst_left--;
      end else if (gaps_on) begin
         gap        = $urandom_range(0, 24);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Drain: nothing due, then a pad, since an item that produces no result
   // (action 3) is never counted as due.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_own_id(input logic [7:0] id);
      quiesce();
      csr_we    <= 1'b1;
      csr_wdata <= id;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // 16 ids spread over the byte (0, 17, .. 255) so the table stays small
   // while every bit toggles
   function automatic logic [7:0] pool_id();
      pool_id = 8'($urandom_range(0, 15) * 17);
   endfunction

   // mostly neighbors that own a link entry, a few from the directed part
   function automatic logic [7:0] pick_neighbor();
      int r;
      r = $urandom_range(0, 8);
      if (r < 6) pick_neighbor = 8'(r * 17);
      else if (r == 6) pick_neighbor = 8'h05;
      else if (r == 7) pick_neighbor = 8'h07;
      else pick_neighbor = 8'hFF;
   endfunction

   // small costs mostly; unreachable, zero and full-range values for saturation
   function automatic logic [15:0] pick_cost();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) pick_cost = COST_MAX;
      else if (r < 20) pick_cost = 16'($urandom_range(0, 65535));
      else if (r < 25) pick_cost = 16'd0;
      else pick_cost = 16'($urandom_range(1, 600));
   endfunction

   // Mostly well-formed traffic: link updates for known neighbors, adverts
   // from them, dumps. Some adverts from random senders as noise. With wide
   // set, destinations and link owners range over all ids to fill the table.
   task automatic random_phase(input int count, input bit wide);
      int          done;
      int          sel;
      logic [1:0]  act;
      logic [7:0]  nb;
      logic [7:0]  dest;
      logic [15:0] cost;
      done = 0;
      while (done < count) begin
         sel  = $urandom_range(0, 99);
         nb   = pick_neighbor();
         dest = (wide && $urandom_range(0, 1)) ? 8'($urandom_range(0, 255)) : pool_id();
         cost = pick_cost();
         if (sel < 20) begin
            act = ACT_LINK;
            if (wide && $urandom_range(0, 1)) nb = 8'($urandom_range(0, 255));
         end else if (sel < 80) begin
            act = ACT_ADVERT;
         end else if (sel < 90) begin
            act = ACT_DUMP;
            if ($urandom_range(0, 2) == 0) nb = 8'($urandom_range(0, 255));
         end else if (sel < 96) begin
            act = ACT_ADVERT;
            nb  = 8'($urandom_range(0, 255));
         end else begin
            act  = ACT_UNUSED;
            nb   = 8'($urandom_range(0, 255));
            dest = 8'($urandom_range(0, 255));
            cost = 16'($urandom_range(0, 65535));
         end
         offer_item(act, nb, dest, cost);
         if (act != ACT_UNUSED) done++;
      end
   endtask

   // Receiver: stall patterns change after a random stretch; one long
   // hold-off on request so the block backs up into its input.
   initial begin : result_sink
      int mode;
      int mode_left;
      int beat;
      mode_left = 0;
      beat      = 0;
      forever begin
         @(posedge clock);
         if (hold_go) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_go = 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            beat++;
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= 1'($urandom_range(0, 1));
               2: rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ((beat % 7) < 2);
            endcase
         end
      end
   end

   // watchdog: cycles with no handshake on either channel
   initial begin : stall_watch
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin : stimulus
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      write_own_id(8'h3C);

      // directed: empty table, unknown neighbor, field extremes
      offer_item(ACT_DUMP,   8'h00, 8'h00, 16'h0000);  // table empty
      offer_item(ACT_ADVERT, 8'h05, 8'h20, 16'h0001);  // neighbor has no link
      offer_item(ACT_LINK,   8'h00, 8'h00, 16'h0000);  // new link, zero id/cost
      offer_item(ACT_LINK,   8'hFF, 8'hFF, 16'hFFFF);  // new link, all ones
      offer_item(ACT_LINK,   8'h05, 8'h00, 16'd10);
      offer_item(ACT_LINK,   8'h07, 8'h00, 16'd3);
      offer_item(ACT_ADVERT, 8'h05, 8'h3C, 16'd1);     // names this node
      offer_item(ACT_ADVERT, 8'h05, 8'h20, 16'd5);     // new route, cost 15
      offer_item(ACT_ADVERT, 8'h07, 8'h20, 16'd20);    // worse via other hop: kept
      offer_item(ACT_ADVERT, 8'h07, 8'h20, 16'd2);     // better: switch to 0x07
      offer_item(ACT_ADVERT, 8'h07, 8'h20, 16'd100);   // same hop: cost rises
      offer_item(ACT_ADVERT, 8'hFF, 8'h40, 16'hFFFF);  // sum saturates
      offer_item(ACT_ADVERT, 8'h00, 8'hFF, 16'h0000);  // link entry rerouted via 0x00
      offer_item(ACT_LINK,   8'hFF, 8'h00, 16'h8000);  // higher, other hop: kept
      offer_item(ACT_LINK,   8'hFF, 8'h00, 16'h0000);  // equal cost: back to direct
      offer_item(ACT_ADVERT, 8'h07, 8'h05, 16'd1);     // link entry via 0x07
      offer_item(ACT_LINK,   8'h05, 8'h00, 16'd50);    // higher, other hop: kept
      offer_item(ACT_LINK,   8'h05, 8'h00, 16'd4);     // equal: direct again
      offer_item(ACT_ADVERT, 8'h05, 8'h00, 16'hFFFF);  // saturated, not lower: kept
      offer_item(ACT_UNUSED, 8'hAA, 8'h55, 16'h1234);  // dropped, no result
      offer_item(ACT_DUMP,   8'h07, 8'h00, 16'h0000);  // poison routes via 0x07
      offer_item(ACT_DUMP,   8'h05, 8'hFF, 16'hFFFF);
      offer_item(ACT_DUMP,   8'hFE, 8'h00, 16'h0000);  // no route via 0xFE
      offer_item(ACT_ADVERT, 8'h99, 8'h3C, 16'd7);     // unknown wins over own id

      // random phases under different own ids, extremes included
      write_own_id(8'h00);
      random_phase(70, 1'b0);

      // back-pressure: receiver holds off while the sender keeps offering
      write_own_id(8'hFF);
      gaps_on = 1'b0;
      hold_go = 1'b1;
      random_phase(40, 1'b0);
      gaps_on = 1'b1;
      random_phase(30, 1'b0);

      write_own_id(8'h88);
      random_phase(70, 1'b0);

      // wide ids: table fills, appends then report table full
      write_own_id(8'($urandom_range(0, 255)));
      random_phase(90, 1'b1);

      quiesce();
      if (mismatch_count == 0 && pending_results == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
